[hdl/srs_pkg.sv]
// shared constants and types for the sample index row sort unit
package srs_pkg;

   localparam int NUM_SAMPLES = 320;
   localparam int ROWS        = 480;
   localparam int ROW_SHIFT   = 4;

   localparam int SAMPLE_W    = 16;
   localparam int INDEX_OUT_W = 9;
   localparam int RSP_DATA_W  = 16;

   localparam int IDX_W     = $clog2(NUM_SAMPLES);
   localparam int ROW_W     = $clog2(ROWS + 1);
   localparam int VAL_ROW_W = SAMPLE_W - ROW_SHIFT;
   localparam int CMP_W     = (VAL_ROW_W > ROW_W) ? VAL_ROW_W : ROW_W;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_FETCH = 1'b1;

   typedef struct packed {
      logic [INDEX_OUT_W-1:0] sample_index;
      logic                   done_res;
   } res_type;

endpackage

[hdl/srs_ram.sv]
// generic single write port ram with registered read
module srs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 320
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/srs_scan.sv]
// sample store, cursors and the row compare sequencer
module srs_scan (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         cmd_valid,
   input  logic                         cmd_type,
   input  logic [srs_pkg::SAMPLE_W-1:0] cmd_value,
   output logic                         idle,
   output logic                         res_valid,
   input  logic                         res_ready,
   output srs_pkg::res_type             res
);
   import srs_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_HOLD = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [IDX_W-1:0]    wp_ff, wp_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   res_type             res_ff, res_in;
   logic                wr_en;
   logic [SAMPLE_W-1:0] rd_data;
   logic                match;
   logic                last_idx;

   srs_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (NUM_SAMPLES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wp_ff),
      .wr_data (cmd_value),
      .rd_addr (idx_in),
      .rd_data (rd_data)
   );

   // read data belongs to idx_ff while scanning
   assign match    = CMP_W'(rd_data >> ROW_SHIFT) == CMP_W'(row_ff);
   assign last_idx = idx_ff == IDX_W'(NUM_SAMPLES - 1);

   always_comb begin
      state_in = state_ff;
      wp_in    = wp_ff;
      idx_in   = idx_ff;
      row_in   = row_ff;
      res_in   = res_ff;
      wr_en    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               if (cmd_type == REQ_LOAD) begin
                  wr_en  = 1'b1;
                  wp_in  = (wp_ff == IDX_W'(NUM_SAMPLES - 1)) ? '0 : wp_ff + 1'b1;
                  row_in = '0;
                  idx_in = '0;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (row_ff == ROW_W'(ROWS)) begin
               res_in.sample_index = '0;
               res_in.done_res     = 1'b1;
               state_in            = ST_HOLD;
            end else begin
               // step to the next entry, rolling over to the next row
               if (last_idx) begin
                  idx_in = '0;
                  row_in = row_ff + 1'b1;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
               if (match) begin
                  res_in.sample_index = INDEX_OUT_W'(idx_ff);
                  res_in.done_res     = 1'b0;
                  state_in            = ST_HOLD;
               end
            end
         end
         ST_HOLD: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wp_ff    <= '0;
         idx_ff   <= '0;
         row_ff   <= '0;
      end else begin
         state_ff <= state_in;
         wp_ff    <= wp_in;
         idx_ff   <= idx_in;
         row_ff   <= row_in;
      end
      res_ff <= res_in;
   end

   assign idle      = state_ff == ST_IDLE;
   assign res_valid = state_ff == ST_HOLD;
   assign res       = res_ff;

endmodule

[hdl/sample_index_row_sort_unit.sv]
// top level: stream ports, output register and the row scan sequencer
// a fetch item examines the store row by row, one ram read and one row compare per cycle,
// until an entry matches the current row or the rows are exhausted; a fetch after the rows
// are exhausted returns a done result without a scan;
// reset clears the write pointer, the row and index cursors and the output valid flag;
// the sample store is not cleared and must be loaded before it is fetched from
module sample_index_row_sort_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [srs_pkg::SAMPLE_W-1:0]   req_tdata,  // [15:0] sample_value
   input  logic                           req_tuser,  // [0] req_type
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [srs_pkg::RSP_DATA_W-1:0] rsp_tdata,  // [8:0] sample_index, rest zero
   output logic                           rsp_tuser   // [0] done_res
);
   import srs_pkg::*;

   logic    idle;
   logic    res_valid;
   logic    res_ready;
   res_type res;
   logic    rsp_valid_ff, rsp_valid_in;
   res_type rsp_ff;

   srs_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (req_tvalid && req_tready),
      .cmd_type  (req_tuser),
      .cmd_value (req_tdata),
      .idle      (idle),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   assign req_tready = idle;
   assign res_ready  = res_valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_ready) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (res_ready) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_ff.sample_index);
   assign rsp_tuser  = rsp_ff.done_res;

   // the sequencer is busy in the cycle after a fetch item is accepted
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == REQ_FETCH) |=> !req_tready)
      else $error("fetch accepted without the sequencer going busy");

   // a load item never produces a result
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == REQ_LOAD && !rsp_tvalid) |=> !rsp_tvalid)
      else $error("result appeared after a load item");

   // a done result carries a zero index
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("done result with nonzero index");

   // a result only waits in the sequencer while the output register is stalled
   assert property (@(posedge clock) disable iff (reset)
      (res_valid && !res_ready) |-> (rsp_tvalid && !rsp_tready))
      else $error("result held back with the output register free");

endmodule

[tb/sample_index_row_sort_unit_tb.sv]
// testbench for the sample index row sort unit: stream driver, monitor and row order predictor
module sample_index_row_sort_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import srs_pkg::*;

   localparam int PLAN  = 0;  // copy of the sorter state used while building stimulus
   localparam int CHECK = 1;  // copy advanced by accepted items
   localparam int unsigned FETCH_SCAN_CAP = 3000;
   localparam int unsigned SCAN_BUDGET    = 450_000;
   localparam int RANDOM_ITEMS            = 920;

   typedef struct packed {
      logic                is_fetch;
      logic [SAMPLE_W-1:0] word;
      logic                drain;
   } req_item_type;

   typedef enum logic [1:0] {READY_ALWAYS, READY_COIN, READY_HOLD} ready_mode_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [SAMPLE_W-1:0]   req_tdata;   // [15:0] sample_value
   logic                  req_tuser;   // [0] req_type
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // [8:0] sample_index, rest zero
   logic                  rsp_tuser;   // [0] done_res

   // sorter state, one copy for planning and one for checking
   logic [SAMPLE_W-1:0] stored_word [2][NUM_SAMPLES];
   logic [IDX_W-1:0]    load_ptr [2];
   logic [ROW_W-1:0]    scan_row [2];
   logic [IDX_W:0]      scan_pos [2];

   req_item_type   pending_items[$];
   res_type        index_due[$];
   int unsigned    scan_spent;
   int             total_items;
   int             items_accepted;
   int             mismatches;
   logic           req_taken;
   int             burst_left;
   int             gap_left;
   ready_mode_type ready_mode;
   int             ready_left;

   sample_index_row_sort_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // one item applied to the sorter state m; scanned counts store entries examined
   function automatic void row_order_step(input int m, input logic is_fetch,
                                          input logic [SAMPLE_W-1:0] word,
                                          output logic has_res, output res_type res,
                                          output int unsigned scanned);
      logic found;
      has_res = 1'b0;
      res     = '0;
      scanned = 0;
      found   = 1'b0;
      if (!is_fetch) begin
         stored_word[m][load_ptr[m]] = word;
         load_ptr[m] = (load_ptr[m] == NUM_SAMPLES - 1) ? '0 : load_ptr[m] + 1'b1;
         scan_row[m] = '0;
         scan_pos[m] = '0;
      end else begin
         has_res = 1'b1;
         while (!found && scan_row[m] < ROWS) begin
            if (scan_pos[m] < NUM_SAMPLES) begin
               scanned++;
               if ((stored_word[m][scan_pos[m]] >> ROW_SHIFT) == scan_row[m]) begin
                  found = 1'b1;
                  res.sample_index = scan_pos[m][INDEX_OUT_W-1:0];
               end
               scan_pos[m] = scan_pos[m] + 1'b1;
            end else begin
               scan_row[m] = scan_row[m] + 1'b1;
               scan_pos[m] = '0;
            end
         end
         if (!found)
            res.done_res = 1'b1;
      end
   endfunction

   // queue an item unless it is a fetch that would scan too long; rolls back if refused
   function automatic bit offer_item(input logic is_fetch, input logic [SAMPLE_W-1:0] word,
                                     input logic drain, input int unsigned cap);
      logic [ROW_W-1:0] saved_row;
      logic [IDX_W:0]   saved_pos;
      logic             has_res;
      res_type          res;
      int unsigned      scanned;
      req_item_type     item;
      saved_row = scan_row[PLAN];
      saved_pos = scan_pos[PLAN];
      row_order_step(PLAN, is_fetch, word, has_res, res, scanned);
      if (scanned > cap || scan_spent + scanned > SCAN_BUDGET + cap) begin
         scan_row[PLAN] = saved_row;
         scan_pos[PLAN] = saved_pos;
         return 1'b0;
      end
      scan_spent += scanned;
      item.is_fetch = is_fetch;
      item.word     = word;
      item.drain    = drain;
      pending_items.push_back(item);
      return 1'b1;
   endfunction

   function automatic logic [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(0, 9))
         0, 1:    return SAMPLE_W'($urandom);
         2:       return SAMPLE_W'($urandom_range(0, ROWS * 16 - 1));
         default: return SAMPLE_W'($urandom_range(0, 127));
      endcase
   endfunction

   // sender: bursts of items separated by random gaps
   always @(negedge clock) begin : sender
      req_item_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_items.size() == 0 ||
                      (pending_items[0].drain && index_due.size() != 0)) begin
            req_tvalid <= 1'b0;
         end else begin
            item = pending_items.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= item.is_fetch ? REQ_FETCH : REQ_LOAD;
            req_tdata  <= item.word;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 16);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
      end
   end

   // receiver: segments of always ready, coin flip and hold low
   always @(negedge clock) begin
      if (ready_left <= 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 2));
         ready_left = (ready_mode == READY_HOLD) ? $urandom_range(1, 12) : $urandom_range(1, 40);
      end
      ready_left--;
      case (ready_mode)
         READY_ALWAYS: rsp_tready <= 1'b1;
         READY_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
         default:      rsp_tready <= 1'b0;
      endcase
   end

   always @(posedge clock) begin : monitor
      logic        has_res;
      res_type     res;
      res_type     want;
      int unsigned scanned;
      req_taken <= !reset && req_tvalid && req_tready;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            row_order_step(CHECK, req_tuser == REQ_FETCH, req_tdata, has_res, res, scanned);
            if (has_res)
               index_due.push_back(res);
            items_accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (index_due.size() == 0) begin
               $error("result item with no fetch waiting: tdata %h tuser %b",
                      rsp_tdata, rsp_tuser);
               mismatches++;
            end else begin
               want = index_due.pop_front();
               if (rsp_tdata[INDEX_OUT_W-1:0] != want.sample_index) begin
                  $error("sample_index: expected %0d, got %0d",
                         want.sample_index, rsp_tdata[INDEX_OUT_W-1:0]);
                  mismatches++;
               end
               if (rsp_tuser != want.done_res) begin
                  $error("done_res: expected %b, got %b", want.done_res, rsp_tuser);
                  mismatches++;
               end
               if (rsp_tdata[RSP_DATA_W-1:INDEX_OUT_W] != '0) begin
                  $error("tdata padding: expected 0, got %h",
                         rsp_tdata[RSP_DATA_W-1:INDEX_OUT_W]);
                  mismatches++;
               end
            end
         end
      end
   end

   task automatic timeout_guard();
      #6ms;
      $display("sample_index_row_sort_unit verification failed");
      $finish;
   endtask

   initial begin
      timeout_guard;
   end

   initial begin : stimulus
      int   random_count;
      int   n_loads;
      int   n_fetches;
      logic drain;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = REQ_LOAD;
      rsp_tready  = 1'b0;
      req_taken   = 1'b0;
      burst_left  = 1;
      gap_left    = 0;
      ready_left  = 0;
      ready_mode  = READY_ALWAYS;
      scan_spent  = 0;
      items_accepted = 0;
      mismatches  = 0;
      for (int m = 0; m < 2; m++) begin
         load_ptr[m] = '0;
         scan_row[m] = '0;
         scan_pos[m] = '0;
      end

      // fill every entry before the first fetch so no unwritten entry is ever scanned
      for (int i = 0; i < NUM_SAMPLES; i++) begin
         case (i)
            0: void'(offer_item(1'b0, 16'hffff, 1'b0, '1));
            1: void'(offer_item(1'b0, 16'h0000, 1'b0, '1));
            2: void'(offer_item(1'b0, SAMPLE_W'(ROWS * 16 - 1), 1'b0, '1));  // last row
            3: void'(offer_item(1'b0, SAMPLE_W'(ROWS * 16), 1'b0, '1));  // first row past the end
            4: void'(offer_item(1'b0, 16'h000f, 1'b0, '1));
            5: void'(offer_item(1'b0, 16'h0010, 1'b0, '1));
            6: void'(offer_item(1'b0, 16'h8000, 1'b0, '1));
            7: void'(offer_item(1'b0, 16'h7fff, 1'b0, '1));
            NUM_SAMPLES - 1: void'(offer_item(1'b0, 16'h0000, 1'b0, '1));
            default: void'(offer_item(1'b0, SAMPLE_W'($urandom_range(ROWS * 16, 65535)),
                                      1'b0, '1));
         endcase
      end
      // walk the whole order, into done, and done again without a load
      for (int i = 0; i < 7; i++)
         void'(offer_item(1'b1, SAMPLE_W'($urandom), 1'b0, '1));
      // a load restarts the order after done
      void'(offer_item(1'b0, 16'h0020, 1'b1, '1));
      for (int i = 0; i < 5; i++)
         void'(offer_item(1'b1, SAMPLE_W'($urandom), 1'b0, '1));

      // random loads followed by runs of fetches; the first item waits for the block to drain
      random_count = 0;
      drain = 1'b1;
      while (random_count < RANDOM_ITEMS) begin
         n_loads = $urandom_range(0, 4);
         for (int i = 0; i < n_loads; i++) begin
            void'(offer_item(1'b0, random_sample(), drain, FETCH_SCAN_CAP));
            drain = ($urandom_range(0, 99) == 0);
            random_count++;
         end
         n_fetches = $urandom_range(1, 10);
         for (int i = 0; i < n_fetches; i++) begin
            if (!offer_item(1'b1, SAMPLE_W'($urandom), drain, FETCH_SCAN_CAP))
               break;
            drain = ($urandom_range(0, 99) == 0);
            random_count++;
         end
      end
      total_items = pending_items.size();

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (items_accepted != total_items || index_due.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("sample_index_row_sort_unit verification clean");
      else
         $display("sample_index_row_sort_unit verification failed");
      $finish;
   end

endmodule
